// ===== src/uiur_pkg.sv =====
// ----------------------------------------------------------------------------
// uiur_pkg
// Shared types, constants and the CRC-32 byte update for the image upload
// receiver.
// ----------------------------------------------------------------------------
package uiur_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int OFF_W = 20;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
  localparam logic [19:0] MAX_IMAGE_RESET = 20'd524288;
  localparam logic [31:0] ENTRY_RESET = 32'h60000000;

  localparam logic [7:0] REPLY_OK = 8'h4B;
  localparam logic [7:0] REPLY_ERR = 8'h45;

  localparam logic [7:0] CMD_SYNC = 8'h55;
  localparam logic [7:0] CMD_HDR = 8'h48;
  localparam logic [7:0] CMD_DATA = 8'h44;
  localparam logic [7:0] CMD_GO = 8'h47;
  localparam logic [7:0] CMD_RUN = 8'h52;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_LAUNCH = 2'd3;

  localparam logic CFG_MAX_IMAGE = 1'b0;
  localparam logic CFG_DEFAULT_ENTRY = 1'b1;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       reply_byte;
    logic [OFF_W-1:0] write_offset;
    logic [7:0]       write_data;
    logic [31:0]      launch_entry;
    logic             program_flash;
  } result_t;

  // Reflected CRC-32, one byte, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
    end
    return v;
  endfunction

endpackage

// ===== src/uiur_stream_if.sv =====
// ----------------------------------------------------------------------------
// uiur_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface uiur_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/uiur_front.sv =====
// ----------------------------------------------------------------------------
// uiur_front
// Command parser: runs the protocol state and CRCs and produces one result
// per item that causes one.
// ----------------------------------------------------------------------------
module uiur_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output uiur_pkg::result_t   res
);
  import uiur_pkg::*;

  typedef enum logic [2:0] {PH_CMD, PH_HDR, PH_DLEN, PH_DDATA, PH_DCRC} phase_t;

  phase_t      phase_r;
  logic [31:0] shift_r, size_r, entry_r, exp_crc_r, ccrc_r, icom_r, itent_r;
  logic [15:0] cnt_r, clen_r;
  logic [19:0] total_r, max_r;
  logic        hdr_seen_r;

  logic [31:0] shift_nxt;
  logic [15:0] cnt_inc;
  logic [20:0] sum_len;
  logic [OFF_W-1:0] off;
  logic [OFFSET_BITS-1:0] off_wrap;

  assign shift_nxt = {rx_byte, shift_r[31:8]};
  assign cnt_inc = cnt_r + 16'd1;
  assign sum_len = {1'b0, total_r} + {5'd0, clen_r};
  assign off_wrap = OFFSET_BITS'(total_r + 20'(cnt_r));
  assign off = OFF_W'(off_wrap);

  // Result decode for the current item.
  always_comb begin
    res_valid = 1'b0;
    res = '0;
    if (step) begin
      unique case (phase_r)
        PH_CMD: begin
          if (rx_byte == CMD_SYNC) begin
            res_valid = 1'b1;
            res.action = ACT_REPLY;
            res.reply_byte = REPLY_OK;
          end else if (rx_byte == CMD_GO || rx_byte == CMD_RUN) begin
            res_valid = 1'b1;
            if (total_r == 20'(size_r) && size_r[31:20] == 12'd0 &&
                (icom_r ^ ALL_ONES) == exp_crc_r) begin
              res.action = ACT_LAUNCH;
              res.reply_byte = REPLY_OK;
              res.launch_entry = entry_r;
              res.program_flash = (rx_byte == CMD_GO);
            end else begin
              res.action = ACT_REPLY;
              res.reply_byte = REPLY_ERR;
            end
          end
        end
        PH_HDR: begin
          if (cnt_inc >= 16'd12) begin
            res_valid = 1'b1;
            res.action = ACT_REPLY;
            res.reply_byte = (size_r != 32'd0 && size_r <= {12'd0, max_r}) ?
                             REPLY_OK : REPLY_ERR;
          end
        end
        PH_DDATA: begin
          res_valid = 1'b1;
          res.action = ACT_WRITE;
          res.write_offset = off;
          res.write_data = rx_byte;
        end
        PH_DCRC: begin
          if (cnt_inc >= 16'd4) begin
            res_valid = 1'b1;
            res.action = ACT_REPLY;
            res.reply_byte = ((ccrc_r ^ ALL_ONES) == shift_nxt &&
                              sum_len <= {1'b0, max_r}) ? REPLY_OK : REPLY_ERR;
          end
        end
        default: ;
      endcase
    end
  end

  // Protocol state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      shift_r <= '0;
      cnt_r <= '0;
      size_r <= '0;
      entry_r <= ENTRY_RESET;
      exp_crc_r <= '0;
      total_r <= '0;
      clen_r <= '0;
      ccrc_r <= ALL_ONES;
      icom_r <= ALL_ONES;
      itent_r <= ALL_ONES;
      hdr_seen_r <= 1'b0;
      max_r <= MAX_IMAGE_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_MAX_IMAGE) begin
          max_r <= cfg_data[19:0];
        end else begin
          if (!hdr_seen_r) entry_r <= cfg_data;
        end
      end
      if (step) begin
        unique case (phase_r)
          PH_CMD: begin
            if (rx_byte == CMD_HDR) begin
              phase_r <= PH_HDR;
              cnt_r <= '0;
              shift_r <= '0;
            end else if (rx_byte == CMD_DATA) begin
              phase_r <= PH_DLEN;
              cnt_r <= '0;
              shift_r <= '0;
            end
          end
          PH_HDR: begin
            shift_r <= shift_nxt;
            cnt_r <= cnt_inc;
            if (cnt_inc == 16'd4) begin
              size_r <= shift_nxt;
            end else if (cnt_inc == 16'd8) begin
              entry_r <= shift_nxt;
            end else if (cnt_inc >= 16'd12) begin
              exp_crc_r <= shift_nxt;
              total_r <= '0;
              icom_r <= ALL_ONES;
              itent_r <= ALL_ONES;
              hdr_seen_r <= 1'b1;
              phase_r <= PH_CMD;
              cnt_r <= '0;
            end
          end
          PH_DLEN: begin
            if (cnt_r == 16'd0) begin
              clen_r <= {8'd0, rx_byte};
              cnt_r <= 16'd1;
            end else begin
              clen_r <= {rx_byte, clen_r[7:0]};
              ccrc_r <= ALL_ONES;
              itent_r <= icom_r;
              cnt_r <= '0;
              shift_r <= '0;
              phase_r <= ({rx_byte, clen_r[7:0]} == 16'd0) ? PH_DCRC : PH_DDATA;
            end
          end
          PH_DDATA: begin
            ccrc_r <= crc_byte(ccrc_r, rx_byte);
            itent_r <= crc_byte(itent_r, rx_byte);
            cnt_r <= cnt_inc;
            if (cnt_inc >= clen_r) begin
              phase_r <= PH_DCRC;
              cnt_r <= '0;
              shift_r <= '0;
            end
          end
          PH_DCRC: begin
            shift_r <= shift_nxt;
            cnt_r <= cnt_inc;
            if (cnt_inc >= 16'd4) begin
              phase_r <= PH_CMD;
              cnt_r <= '0;
              if ((ccrc_r ^ ALL_ONES) == shift_nxt && sum_len <= {1'b0, max_r}) begin
                total_r <= sum_len[19:0];
                icom_r <= itent_r;
              end
            end
          end
          default: begin
            phase_r <= PH_CMD;
            cnt_r <= '0;
          end
        endcase
      end
    end
  end

endmodule

// ===== src/uiur_queue.sv =====
// ----------------------------------------------------------------------------
// uiur_queue
// Two-entry result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module uiur_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  uiur_pkg::result_t push_data,
  output logic              has_room,
  output logic              pop_valid,
  output uiur_pkg::result_t pop_data,
  input  logic              pop
);
  import uiur_pkg::*;

  result_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign has_room = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// ===== src/uart_image_upload_receiver.sv =====
// ----------------------------------------------------------------------------
// uart_image_upload_receiver
// Parses the serial upload protocol and emits replies, memory writes and
// launch requests.
// Each result is written into the result queue and offered from its head.
// Throughput: one item per cycle while the two-entry result queue has room; it absorbs output stalls.
// Reset: synchronous on rst_n; parser returns to command phase, registers
// to their defaults, queue empties.
// ----------------------------------------------------------------------------
module uart_image_upload_receiver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  uiur_stream_if.sink         in_ch,
  uiur_stream_if.source       out_ch
);
  import uiur_pkg::*;

  logic    step, res_valid, has_room, pop_valid;
  result_t res, pop_data;

  // Accept only with room for a possible result.
  assign in_ch.ready = has_room;
  assign step = in_ch.valid && has_room;

  uiur_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .step, .rx_byte(in_ch.data[7:0]), .res_valid, .res
  );

  uiur_queue u_queue (
    .clk, .rst_n, .push(res_valid), .push_data(res), .has_room,
    .pop_valid, .pop_data, .pop(pop_valid && out_ch.ready)
  );

  assign out_ch.valid = pop_valid;
  assign out_ch.data = pop_data;

endmodule

// ===== src/uiur_checker.sv =====
// ----------------------------------------------------------------------------
// uiur_checker
// Port-level checks for the upload receiver.
// ----------------------------------------------------------------------------
module uiur_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [70:0] out_data
);
  import uiur_pkg::*;

  result_t r;
  assign r = out_data;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  // No results right after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("rst");
  // A write never carries a reply byte.
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && r.action == ACT_WRITE |-> r.reply_byte == 8'd0) else $error("wr");
  // A launch always acknowledges with K.
  a_la: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && r.action == ACT_LAUNCH |-> r.reply_byte == REPLY_OK) else $error("la");
  // The input is held off only while results are waiting to leave.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid) else $error("full");
endmodule

bind uart_image_upload_receiver uiur_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
